FILE: rtl/core/rlhm_pkg.sv
// Shared types, constants and helpers for the request latency histogram monitor.
package rlhm_pkg;

  localparam int CW          = 64;
  localparam int VAL_W       = 64;
  localparam int NUM_BUCKETS = 19;
  localparam int BKT_W       = $clog2(NUM_BUCKETS);
  localparam int NUM_STATS   = 13;
  localparam int SID_W       = 4;
  localparam int PCT_W       = 7;
  localparam int PROD_W      = VAL_W + PCT_W;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef logic [CW-1:0]    cnt_t;
  typedef logic [VAL_W-1:0] val_t;
  typedef logic [BKT_W-1:0] bkt_idx_t;
  typedef logic [SID_W-1:0] sid_t;
  typedef logic [PCT_W-1:0] pct_t;
  typedef logic [PROD_W-1:0] prod_t;

  localparam logic [2:0] CMD_START  = 3'd0;
  localparam logic [2:0] CMD_FINISH = 3'd1;
  localparam logic [2:0] CMD_RETRY  = 3'd2;
  localparam logic [2:0] CMD_OPEN   = 3'd3;
  localparam logic [2:0] CMD_CLOSE  = 3'd4;
  localparam logic [2:0] CMD_SNAP   = 3'd5;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_TIMEOUT = 2'd1;

  localparam sid_t STAT_TOTAL   = 4'd0;
  localparam sid_t STAT_OK      = 4'd1;
  localparam sid_t STAT_FAILED  = 4'd2;
  localparam sid_t STAT_TIMEOUT = 4'd3;
  localparam sid_t STAT_RETRY   = 4'd4;
  localparam sid_t STAT_INFL    = 4'd5;
  localparam sid_t STAT_CONNS   = 4'd6;
  localparam sid_t STAT_SAMPLES = 4'd7;
  localparam sid_t STAT_LATSUM  = 4'd8;
  localparam sid_t STAT_MAX     = 4'd9;
  localparam sid_t STAT_P50     = 4'd10;
  localparam sid_t STAT_P95     = 4'd11;
  localparam sid_t STAT_P99     = 4'd12;

  localparam pct_t PCT_SCALE = 7'd100;

  localparam bkt_idx_t BKT_LAST = BKT_W'(NUM_BUCKETS - 1);

  localparam val_t BUCKET_BOUND [NUM_BUCKETS] = '{
    64'd100, 64'd250, 64'd500, 64'd1000, 64'd2500, 64'd5000, 64'd10000,
    64'd25000, 64'd50000, 64'd100000, 64'd250000, 64'd500000, 64'd1000000,
    64'd2500000, 64'd5000000, 64'd10000000, 64'd30000000, 64'd60000000,
    64'hFFFF_FFFF_FFFF_FFFF
  };

  typedef enum logic [2:0] {
    OP_START,
    OP_FINISH,
    OP_RETRY,
    OP_OPEN,
    OP_CLOSE,
    OP_SNAP,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t      op;
    logic     fail;
    logic     timeout;
    val_t     lat;
    bkt_idx_t bkt;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BS_RUN,
    BS_STAT,
    BS_PSETUP,
    BS_PADD,
    BS_PCMP,
    BS_PREADY
  } back_state_t;

  function automatic pct_t pct_of(input sid_t sid);
    pct_t p;
    case (sid)
      STAT_P50: p = 7'd50;
      STAT_P95: p = 7'd95;
      default:  p = 7'd99;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/core/rlhm_front.sv
// Front end: accepts events, decodes the command, clamps latency, picks the bucket.
module rlhm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          command,
  input  logic [1:0]          status,
  input  logic signed [63:0]  latency,
  input  rlhm_pkg::q_status_t q_st,
  output logic                push,
  output rlhm_pkg::q_item_t   push_item
);

  logic              fv;
  rlhm_pkg::q_item_t item;
  rlhm_pkg::q_item_t item_next;
  logic              accept;

  assign in_stall  = fv && q_st.full;
  assign push      = fv && !q_st.full;
  assign accept    = in_valid && !in_stall;
  assign push_item = item;

  always_comb begin
    item_next = '0;
    case (command)
      rlhm_pkg::CMD_START:  item_next.op = rlhm_pkg::OP_START;
      rlhm_pkg::CMD_FINISH: item_next.op = rlhm_pkg::OP_FINISH;
      rlhm_pkg::CMD_RETRY:  item_next.op = rlhm_pkg::OP_RETRY;
      rlhm_pkg::CMD_OPEN:   item_next.op = rlhm_pkg::OP_OPEN;
      rlhm_pkg::CMD_CLOSE:  item_next.op = rlhm_pkg::OP_CLOSE;
      rlhm_pkg::CMD_SNAP:   item_next.op = rlhm_pkg::OP_SNAP;
      default:              item_next.op = rlhm_pkg::OP_NONE;
    endcase
    item_next.fail    = (status != rlhm_pkg::STS_OK);
    item_next.timeout = (status == rlhm_pkg::STS_TIMEOUT);
    item_next.lat     = latency[63] ? '0 : rlhm_pkg::val_t'(latency);
    item_next.bkt     = rlhm_pkg::BKT_LAST;
    for (int i = rlhm_pkg::NUM_BUCKETS - 1; i >= 0; i--) begin
      if (rlhm_pkg::BUCKET_BOUND[i] >= item_next.lat) begin
        item_next.bkt = rlhm_pkg::BKT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (accept) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

FILE: rtl/core/rlhm_queue.sv
// Short request queue between the front end and the back end.
module rlhm_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rlhm_pkg::q_item_t   push_item,
  input  logic                pop,
  output rlhm_pkg::q_item_t   head,
  output rlhm_pkg::q_status_t q_st
);

  localparam logic [rlhm_pkg::QPTR_W-1:0] PTR_LAST = rlhm_pkg::QPTR_W'(rlhm_pkg::QDEPTH - 1);
  localparam logic [rlhm_pkg::QCNT_W-1:0] CNT_FULL = rlhm_pkg::QCNT_W'(rlhm_pkg::QDEPTH);

  rlhm_pkg::q_item_t              mem [rlhm_pkg::QDEPTH];
  logic [rlhm_pkg::QPTR_W-1:0]    wptr;
  logic [rlhm_pkg::QPTR_W-1:0]    rptr;
  logic [rlhm_pkg::QCNT_W-1:0]    count;
  logic                           do_push;
  logic                           do_pop;

  assign q_st.full  = (count == CNT_FULL);
  assign q_st.empty = (count == '0);
  assign do_push    = push && !q_st.full;
  assign do_pop     = pop && !q_st.empty;
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_item;
    end
  end

endmodule

FILE: rtl/core/rlhm_back.sv
// Back end: counter and histogram updates, snapshot sequencing and percentile walk.
module rlhm_back (
  input  logic                          clk,
  input  logic                          rst,
  input  rlhm_pkg::q_item_t             head,
  input  rlhm_pkg::q_status_t           q_st,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rlhm_pkg::SID_W-1:0]    stat_id,
  output logic [rlhm_pkg::VAL_W-1:0]    stat_value,
  output logic                          last
);

  rlhm_pkg::back_state_t state;
  rlhm_pkg::back_state_t state_next;

  rlhm_pkg::cnt_t     total_cnt;
  rlhm_pkg::cnt_t     ok_cnt;
  rlhm_pkg::cnt_t     fail_cnt;
  rlhm_pkg::cnt_t     tmo_cnt;
  rlhm_pkg::cnt_t     retry_cnt;
  rlhm_pkg::cnt_t     infl;
  rlhm_pkg::cnt_t     conns;
  rlhm_pkg::cnt_t     samples;
  rlhm_pkg::cnt_t     lat_sum;
  rlhm_pkg::val_t     lat_max;
  rlhm_pkg::cnt_t     bkt [rlhm_pkg::NUM_BUCKETS];

  rlhm_pkg::sid_t     sid;
  rlhm_pkg::bkt_idx_t bi;
  rlhm_pkg::val_t     acc;
  rlhm_pkg::prod_t    pn;
  rlhm_pkg::val_t     pval;

  logic               out_free;
  logic               out_load;
  logic               hit;
  logic               walk_end;
  rlhm_pkg::val_t     stat_sel;

  assign out_free = !out_valid || !out_stall;
  assign hit      = (rlhm_pkg::prod_t'(acc) * rlhm_pkg::prod_t'(rlhm_pkg::PCT_SCALE)) >= pn;
  assign walk_end = hit || (bi == rlhm_pkg::BKT_LAST);

  always_comb begin
    state_next = state;
    case (state)
      rlhm_pkg::BS_RUN: begin
        if (!q_st.empty && head.op == rlhm_pkg::OP_SNAP) begin
          state_next = rlhm_pkg::BS_STAT;
        end
      end
      rlhm_pkg::BS_STAT: begin
        if (sid >= rlhm_pkg::STAT_P50) begin
          state_next = rlhm_pkg::BS_PSETUP;
        end
      end
      rlhm_pkg::BS_PSETUP: begin
        state_next = (samples == '0) ? rlhm_pkg::BS_PREADY : rlhm_pkg::BS_PADD;
      end
      rlhm_pkg::BS_PADD: begin
        state_next = rlhm_pkg::BS_PCMP;
      end
      rlhm_pkg::BS_PCMP: begin
        state_next = walk_end ? rlhm_pkg::BS_PREADY : rlhm_pkg::BS_PADD;
      end
      rlhm_pkg::BS_PREADY: begin
        if (out_free) begin
          state_next = (sid == rlhm_pkg::STAT_P99) ? rlhm_pkg::BS_RUN : rlhm_pkg::BS_PSETUP;
        end
      end
      default: state_next = rlhm_pkg::BS_RUN;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    case (state)
      rlhm_pkg::BS_RUN:    pop      = !q_st.empty;
      rlhm_pkg::BS_STAT:   out_load = out_free && (sid < rlhm_pkg::STAT_P50);
      rlhm_pkg::BS_PREADY: out_load = out_free;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (sid)
      rlhm_pkg::STAT_TOTAL:   stat_sel = rlhm_pkg::val_t'(total_cnt);
      rlhm_pkg::STAT_OK:      stat_sel = rlhm_pkg::val_t'(ok_cnt);
      rlhm_pkg::STAT_FAILED:  stat_sel = rlhm_pkg::val_t'(fail_cnt);
      rlhm_pkg::STAT_TIMEOUT: stat_sel = rlhm_pkg::val_t'(tmo_cnt);
      rlhm_pkg::STAT_RETRY:   stat_sel = rlhm_pkg::val_t'(retry_cnt);
      rlhm_pkg::STAT_INFL:    stat_sel = rlhm_pkg::val_t'(infl);
      rlhm_pkg::STAT_CONNS:   stat_sel = rlhm_pkg::val_t'(conns);
      rlhm_pkg::STAT_SAMPLES: stat_sel = rlhm_pkg::val_t'(samples);
      rlhm_pkg::STAT_LATSUM:  stat_sel = rlhm_pkg::val_t'(lat_sum);
      rlhm_pkg::STAT_MAX:     stat_sel = lat_max;
      default:                stat_sel = pval;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rlhm_pkg::BS_RUN;
      out_valid <= 1'b0;
      sid       <= '0;
      total_cnt <= '0;
      ok_cnt    <= '0;
      fail_cnt  <= '0;
      tmo_cnt   <= '0;
      retry_cnt <= '0;
      infl      <= '0;
      conns     <= '0;
      samples   <= '0;
      lat_sum   <= '0;
      lat_max   <= '0;
      for (int i = 0; i < rlhm_pkg::NUM_BUCKETS; i++) begin
        bkt[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
        sid       <= sid + 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        case (head.op)
          rlhm_pkg::OP_START: begin
            total_cnt <= total_cnt + 1'b1;
            infl      <= infl + 1'b1;
          end
          rlhm_pkg::OP_FINISH: begin
            infl    <= (infl != '0) ? infl - 1'b1 : '0;
            samples <= samples + 1'b1;
            lat_sum <= lat_sum + head.lat[rlhm_pkg::CW-1:0];
            if (head.lat > lat_max) begin
              lat_max <= head.lat;
            end
            if (!head.fail) begin
              ok_cnt <= ok_cnt + 1'b1;
            end else begin
              fail_cnt <= fail_cnt + 1'b1;
              if (head.timeout) begin
                tmo_cnt <= tmo_cnt + 1'b1;
              end
            end
            for (int i = 0; i < rlhm_pkg::NUM_BUCKETS; i++) begin
              if (head.bkt == rlhm_pkg::BKT_W'(i)) begin
                bkt[i] <= bkt[i] + 1'b1;
              end
            end
          end
          rlhm_pkg::OP_RETRY: retry_cnt <= retry_cnt + 1'b1;
          rlhm_pkg::OP_OPEN:  conns     <= conns + 1'b1;
          rlhm_pkg::OP_CLOSE: conns     <= (conns != '0) ? conns - 1'b1 : '0;
          rlhm_pkg::OP_SNAP:  sid       <= rlhm_pkg::STAT_TOTAL;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      stat_id    <= sid;
      stat_value <= stat_sel;
      last       <= (sid == rlhm_pkg::STAT_P99);
    end
    case (state)
      rlhm_pkg::BS_PSETUP: begin
        pn   <= rlhm_pkg::prod_t'(samples) * rlhm_pkg::prod_t'(rlhm_pkg::pct_of(sid));
        acc  <= '0;
        bi   <= '0;
        pval <= '0;
      end
      rlhm_pkg::BS_PADD: begin
        acc <= acc + rlhm_pkg::val_t'(bkt[bi]);
      end
      rlhm_pkg::BS_PCMP: begin
        if (walk_end) begin
          pval <= (bi == rlhm_pkg::BKT_LAST) ? lat_max : rlhm_pkg::BUCKET_BOUND[bi];
        end else begin
          bi <= bi + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/request_latency_histogram_monitor_top.sv
// Request latency histogram monitor: event counters, gauges, 19-bucket
// latency histogram and a 13-statistic snapshot with p50/p95/p99. Events are
// decoded and bucketed in a registered front stage, pass a four-entry queue
// and are applied by the back end at one request per cycle while no
// snapshot holds it, so a steady stream of events then runs at one per
// cycle. A snapshot holds the back end while it sends its statistics:
// the ten counter, gauge, sum and maximum values at one per cycle while
// the output is not stalled, then it turns to the percentiles; each
// percentile walks the histogram bucket by bucket (add, then compare
// against n*p) between a setup step and a hand-off step. With no samples
// the walk is skipped and the percentile is zero; a walk that reaches the
// last bucket reports the maximum latency. A stalled output holds the
// snapshot further. Events keep entering the queue meanwhile until it fills.
module request_latency_histogram_monitor_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 command,
  input  logic [1:0]                 status,
  input  logic signed [63:0]         latency,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rlhm_pkg::SID_W-1:0] stat_id,
  output logic [rlhm_pkg::VAL_W-1:0] stat_value,
  output logic                       last
);

  rlhm_pkg::q_status_t q_st;
  rlhm_pkg::q_item_t   push_item;
  rlhm_pkg::q_item_t   head;
  logic                push;
  logic                pop;

  rlhm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .status     (status),
    .latency    (latency),
    .q_st       (q_st),
    .push       (push),
    .push_item  (push_item)
  );

  rlhm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_st      (q_st)
  );

  rlhm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_st       (q_st),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat_id    (stat_id),
    .stat_value (stat_value),
    .last       (last)
  );

endmodule
